// ----- hw/rtl/sorted_priority_queue_top_assert.svh -----
// Assertion macros for the priority queue.
// Each one samples on i_clk and is off while i_rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Condition holds at every edge.
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds at the same edge as the antecedent.
`define SPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_TAG_BITS      = 64;
    localparam int DEF_PRIORITY_BITS = 16;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_POP    = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_END,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic issue;
        logic wrap_up;
        logic finish;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan;
        logic last_issue;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_ctrl.sv -----
`default_nettype none

module spq_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  spq_pkg::t_dp_status     i_dp_st,
    output spq_pkg::t_ctl_cmd       o_ctl
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = i_dp_st.scan ? S_SCAN : S_END;
                end
            end
            S_SCAN: begin
                o_ctl.issue = 1'b1;
                if (i_dp_st.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read word is handled this cycle
                n_state = S_END;
            end
            S_END: begin
                o_ctl.wrap_up = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_dp_st.out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/spq_dp.sv -----
`default_nettype none
`include "sorted_priority_queue_top_assert.svh"

module spq_dp #(
    parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  spq_pkg::t_ctl_cmd                     i_ctl,
    output spq_pkg::t_dp_status                   o_dp_st,
    input  wire  [2:0]                            i_cmd,
    input  wire  [TAG_BITS-1:0]                   i_item_tag,
    input  wire  [PRIORITY_BITS-1:0]              i_new_priority,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [1:0]                            o_status,
    output logic [TAG_BITS-1:0]                   o_out_tag,
    output logic [PRIORITY_BITS-1:0]              o_out_priority,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      o_removed_count,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      o_occupancy
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // entry store, slot 0 is the head
    logic [TAG_BITS-1:0]      r_mem_tag [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] r_mem_pri [QUEUE_DEPTH];

    logic                     r_go;
    logic                     r_rd_vld;
    logic                     r_out_valid;
    logic [CW-1:0]            r_count;

    logic [2:0]               r_cmd;
    logic [TAG_BITS-1:0]      r_tag;
    logic [PRIORITY_BITS-1:0] r_pri;
    t_status                  r_stat;
    logic [CW-1:0]            r_left;
    logic [AW-1:0]            r_rd_ptr;
    logic [AW-1:0]            r_rd_idx;
    logic [TAG_BITS-1:0]      r_rd_tag;
    logic [PRIORITY_BITS-1:0] r_rd_pri;
    logic [CW-1:0]            r_wptr;
    logic [CW-1:0]            r_removed;
    logic                     r_placed;
    logic                     r_found;
    logic [TAG_BITS-1:0]      r_otag;
    logic [PRIORITY_BITS-1:0] r_opri;

    t_status                  r_o_stat;
    logic [TAG_BITS-1:0]      r_o_tag;
    logic [PRIORITY_BITS-1:0] r_o_pri;
    logic [CW-1:0]            r_o_rem;
    logic [CW-1:0]            r_o_occ;

    logic                     in_ins, in_pop, in_find, in_del, in_clr;
    logic                     is_ins, is_pop, is_find, is_del;
    logic                     q_full, q_empty, in_go;
    t_status                  in_stat;
    logic                     tag_hit, drop;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [TAG_BITS-1:0]      wr_tag;
    logic [PRIORITY_BITS-1:0] wr_pri;

    assign in_ins  = (i_cmd == CMD_INSERT);
    assign in_pop  = (i_cmd == CMD_POP);
    assign in_find = (i_cmd == CMD_FIND);
    assign in_del  = (i_cmd == CMD_DELETE);
    assign in_clr  = (i_cmd == CMD_CLEAR);

    assign is_ins  = (r_cmd == CMD_INSERT);
    assign is_pop  = (r_cmd == CMD_POP);
    assign is_find = (r_cmd == CMD_FIND);
    assign is_del  = (r_cmd == CMD_DELETE);

    assign q_full  = (r_count == CW'(QUEUE_DEPTH));
    assign q_empty = (r_count == '0);
    assign in_go   = (in_ins && !q_full) || ((in_pop || in_find || in_del) && !q_empty);

    always_comb begin
        in_stat = ST_OK;
        if (in_ins && q_full) begin
            in_stat = ST_FULL;
        end else if ((in_pop || in_find || in_del) && q_empty) begin
            in_stat = ST_EMPTY;
        end
    end

    assign o_dp_st = '{
        scan:       in_go && !q_empty,
        last_issue: (r_left == CW'(1)),
        out_free:   !r_out_valid || !i_out_stall
    };

    assign tag_hit = (r_rd_tag == r_tag);

    // Insert walks from the tail, moving lower priorities one slot back until
    // the new word lands. Pop and delete compact toward the head.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_tag  = r_tag;
        wr_pri  = r_pri;
        drop    = 1'b0;
        if (r_rd_vld) begin
            if (is_ins) begin
                if (!r_placed) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_idx + AW'(1);
                    if (r_rd_pri < r_pri) begin
                        wr_tag = r_rd_tag;
                        wr_pri = r_rd_pri;
                    end
                end
            end else if (is_pop || is_del) begin
                drop = is_pop ? (r_rd_idx == '0) : tag_hit;
                if (!drop) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wptr[AW-1:0];
                    wr_tag  = r_rd_tag;
                    wr_pri  = r_rd_pri;
                end
            end
        end else if (i_ctl.wrap_up && r_go && is_ins && !r_placed) begin
            // nothing ranked at or above the new word: it becomes the head
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_tag[wr_addr] <= wr_tag;
            r_mem_pri[wr_addr] <= wr_pri;
        end
        if (i_ctl.issue) begin
            r_rd_tag <= r_mem_tag[r_rd_ptr];
            r_rd_pri <= r_mem_pri[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go        <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_rd_vld <= i_ctl.issue;
            if (i_ctl.load) begin
                r_go <= in_go;
                if (in_clr) begin
                    r_count <= '0;
                end
            end
            if (i_ctl.wrap_up && r_go) begin
                if (is_ins) begin
                    r_count <= r_count + CW'(1);
                end else if (is_pop || is_del) begin
                    r_count <= r_wptr;
                end
            end
            if (i_ctl.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= i_cmd;
            r_tag     <= i_item_tag;
            r_pri     <= i_new_priority;
            r_stat    <= in_stat;
            r_left    <= r_count;
            r_rd_ptr  <= in_ins ? AW'(r_count - CW'(1)) : '0;
            r_wptr    <= '0;
            r_removed <= in_clr ? r_count : '0;
            r_placed  <= 1'b0;
            r_found   <= 1'b0;
            r_otag    <= '0;
            r_opri    <= '0;
        end
        if (i_ctl.issue) begin
            r_rd_idx <= r_rd_ptr;
            r_rd_ptr <= is_ins ? r_rd_ptr - AW'(1) : r_rd_ptr + AW'(1);
            r_left   <= r_left - CW'(1);
        end
        if (r_rd_vld) begin
            if (is_ins && !r_placed && !(r_rd_pri < r_pri)) begin
                r_placed <= 1'b1;
            end
            if (is_pop || is_del) begin
                if (drop) begin
                    if (is_del) begin
                        r_removed <= r_removed + CW'(1);
                    end else begin
                        r_otag <= r_rd_tag;
                        r_opri <= r_rd_pri;
                    end
                end else begin
                    r_wptr <= r_wptr + CW'(1);
                end
            end
            if (is_find && tag_hit && !r_found) begin
                r_found <= 1'b1;
                r_otag  <= r_rd_tag;
                r_opri  <= r_rd_pri;
            end
        end
        if (i_ctl.wrap_up && r_go) begin
            if ((is_find && !r_found) || (is_del && (r_removed == '0))) begin
                r_stat <= ST_NOTFOUND;
            end
        end
        if (i_ctl.finish) begin
            r_o_stat <= r_stat;
            r_o_tag  <= r_otag;
            r_o_pri  <= r_opri;
            r_o_rem  <= r_removed;
            r_o_occ  <= r_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_stat;
    assign o_out_tag       = r_o_tag;
    assign o_out_priority  = r_o_pri;
    assign o_removed_count = r_o_rem;
    assign o_occupancy     = r_o_occ;

    `SPQ_ASSERT_ALWAYS(a_count_range, r_count <= CW'(QUEUE_DEPTH), "occupancy above depth")
    `SPQ_ASSERT_IMPLY(a_compact_behind, r_rd_vld && (is_pop || is_del), r_wptr <= CW'(r_rd_idx), "compaction write ahead of read")
    `SPQ_ASSERT_IMPLY(a_finish_free, i_ctl.finish, !r_out_valid || !i_out_stall, "result overwrites a pending word")
    `SPQ_ASSERT_IMPLY(a_read_active, r_rd_vld, r_go, "entry read for a command that does no scan")

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue_top.sv -----
// Channel  Dir  Handshake                  Words
// -------  ---  -------------------------  ------------------------------------------
// in       in   i_in_valid / o_in_stall    i_cmd, i_item_tag, i_new_priority
// out      out  o_out_valid / i_out_stall  o_status, o_out_tag, o_out_priority,
//                                          o_removed_count, o_occupancy
//
// Insert into a non-empty queue that is not full, and pop, find or delete on a
// non-empty queue scan every entry; every other command skips the scan. The
// scan is paced by the entry memory's single read port: one entry per cycle.
// Synchronous reset empties the queue at once; entries are not cleared.
// A result waits in the output register while the next word is accepted; that
// command's result is held back until the register frees.
`default_nettype none

module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire  [2:0]                            i_cmd,
    input  wire  [TAG_BITS-1:0]                   i_item_tag,
    input  wire  [PRIORITY_BITS-1:0]              i_new_priority,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [1:0]                            o_status,
    output logic [TAG_BITS-1:0]                   o_out_tag,
    output logic [PRIORITY_BITS-1:0]              o_out_priority,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      o_removed_count,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]      o_occupancy
);
    import spq_pkg::*;

    t_ctl_cmd   ctl;
    t_dp_status dp_st;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_dp_st    (dp_st),
        .o_ctl      (ctl)
    );

    spq_dp #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_dp_st         (dp_st),
        .i_cmd           (i_cmd),
        .i_item_tag      (i_item_tag),
        .i_new_priority  (i_new_priority),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_out_tag       (o_out_tag),
        .o_out_priority  (o_out_priority),
        .o_removed_count (o_removed_count),
        .o_occupancy     (o_occupancy)
    );

endmodule

`default_nettype wire
